### rtl/lpps_pkg.sv
// Shared types, constants and width helpers for the line position PID steering block.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package lpps_pkg;

    // Defaults for the top-level parameters
    localparam int SENSOR_COUNT_DEF = 8;
    localparam int SAMPLE_BITS_DEF  = 16;

    // Fixed field widths
    localparam int INPUT_COUNT    = 8;
    localparam int DATA_BITS      = 16;
    localparam int GAIN_BITS      = 16;
    localparam int POS_BITS       = 12;
    localparam int FRAC_BITS      = 8;
    localparam int ERR_BITS       = 13;
    localparam int INTEG_BITS     = 32;
    localparam int DRIVE_BITS     = 10;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    // Shared multiplier: unsigned gain (zero-extended) times a signed 32-bit operand
    localparam int MUL_A_BITS = GAIN_BITS + 1;
    localparam int MUL_B_BITS = INTEG_BITS;
    localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
    localparam int ACC_BITS   = PROD_BITS + 2;
    localparam int ACC_SHIFT  = 16;

    // Limits and reset values
    localparam int DRIVE_LIMIT = 510;
    localparam int POS_MIN     = 256;
    localparam logic [POS_BITS-1:0]  TARGET_RESET     = 12'd1152;
    localparam logic [GAIN_BITS-1:0] PROP_GAIN_RESET  = 16'd51200;
    localparam logic [GAIN_BITS-1:0] INTEG_GAIN_RESET = 16'd51;
    localparam logic [GAIN_BITS-1:0] DERIV_GAIN_RESET = 16'd30720;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Register indexes on the configuration port
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PROP_GAIN  = 2'd0,
        CFG_INTEG_GAIN = 2'd1,
        CFG_DERIV_GAIN = 2'd2,
        CFG_TARGET     = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SUM,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIV,
        B_ERR,
        B_MP,
        B_MI,
        B_MD,
        B_SUM,
        B_DONE
    } back_state_t;

    // Width of the plain sum of sc readings of sb bits
    function automatic int plain_width(input int sc, input int sb);
        return sb + $clog2(sc);
    endfunction

    // Width of the weighted sum, weights 1 to sc
    function automatic int weight_width(input int sc, input int sb);
        return sb + $clog2(sc * (sc + 1)) - 1;
    endfunction

endpackage

### rtl/line_position_pid_steering.sv
// Top level of the line position PID steering block: configuration registers and
// the front end, queue and back end. Depends on lpps_pkg, lpps_front, lpps_queue, lpps_back.
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_stall    sensor_0 .. sensor_7
//  out      output     out_valid / out_stall  position, line_lost, drive, turn_right
//  cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  The front end adds one lane per cycle to its sums.
//  The back end works through each item in steps (pop, 12-step restoring divide, error,
//  three products on the one shared 17x32 multiplier, final add, output load) and skips
//  the divide when the line is lost; the back end sets the sustained rate.
//  A two-entry queue sits between the two.
//  Reset clears control state, the integral and previous error, and sets the last
//  position and the registers to their defaults. Configuration writes are always taken.
//  A stalled result holds the back end in its final step; the front end keeps working until the queue is full.
module line_position_pid_steering #(
    parameter int SENSOR_COUNT = lpps_pkg::SENSOR_COUNT_DEF,
    parameter int SAMPLE_BITS  = lpps_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [lpps_pkg::DATA_BITS-1:0]         sensor_0,
    input  logic [lpps_pkg::DATA_BITS-1:0]         sensor_1,
    input  logic [lpps_pkg::DATA_BITS-1:0]         sensor_2,
    input  logic [lpps_pkg::DATA_BITS-1:0]         sensor_3,
    input  logic [lpps_pkg::DATA_BITS-1:0]         sensor_4,
    input  logic [lpps_pkg::DATA_BITS-1:0]         sensor_5,
    input  logic [lpps_pkg::DATA_BITS-1:0]         sensor_6,
    input  logic [lpps_pkg::DATA_BITS-1:0]         sensor_7,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [lpps_pkg::POS_BITS-1:0]          position,
    output logic                                   line_lost,
    output logic signed [lpps_pkg::DRIVE_BITS-1:0] drive,
    output logic                                   turn_right,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [lpps_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [lpps_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    localparam int PLAIN_W  = lpps_pkg::plain_width(SENSOR_COUNT, SAMPLE_BITS);
    localparam int WEIGHT_W = lpps_pkg::weight_width(SENSOR_COUNT, SAMPLE_BITS);
    localparam int ITEM_W   = WEIGHT_W + PLAIN_W + 1;

    logic [lpps_pkg::INPUT_COUNT-1:0][lpps_pkg::DATA_BITS-1:0] sensor_bus;
    logic [lpps_pkg::GAIN_BITS-1:0] prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic [lpps_pkg::POS_BITS-1:0]  target_reg;
    logic                           push, full, pop, empty;
    logic [WEIGHT_W-1:0]            f_weighted, q_weighted;
    logic [PLAIN_W-1:0]             f_plain, q_plain;
    logic                           f_lost, q_lost;
    logic [ITEM_W-1:0]              q_rdata;

    assign sensor_bus[0] = sensor_0;
    assign sensor_bus[1] = sensor_1;
    assign sensor_bus[2] = sensor_2;
    assign sensor_bus[3] = sensor_3;
    assign sensor_bus[4] = sensor_4;
    assign sensor_bus[5] = sensor_5;
    assign sensor_bus[6] = sensor_6;
    assign sensor_bus[7] = sensor_7;

    // Configuration registers, written on every cfg transfer
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= lpps_pkg::PROP_GAIN_RESET;
            integ_gain_reg <= lpps_pkg::INTEG_GAIN_RESET;
            deriv_gain_reg <= lpps_pkg::DERIV_GAIN_RESET;
            target_reg     <= lpps_pkg::TARGET_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lpps_pkg::CFG_PROP_GAIN:  prop_gain_reg  <= cfg_data;
                lpps_pkg::CFG_INTEG_GAIN: integ_gain_reg <= cfg_data;
                lpps_pkg::CFG_DERIV_GAIN: deriv_gain_reg <= cfg_data;
                lpps_pkg::CFG_TARGET:     target_reg     <= cfg_data[lpps_pkg::POS_BITS-1:0];
                default:                  target_reg     <= target_reg;
            endcase
        end
    end

    lpps_front #(
        .SENSOR_COUNT (SENSOR_COUNT),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .PLAIN_W      (PLAIN_W),
        .WEIGHT_W     (WEIGHT_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sensors  (sensor_bus),
        .push     (push),
        .full     (full),
        .weighted (f_weighted),
        .plain    (f_plain),
        .lost     (f_lost)
    );

    lpps_queue #(
        .WIDTH (ITEM_W)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata ({f_lost, f_plain, f_weighted}),
        .full  (full),
        .pop   (pop),
        .rdata (q_rdata),
        .empty (empty)
    );

    assign q_weighted = q_rdata[WEIGHT_W-1:0];
    assign q_plain    = q_rdata[WEIGHT_W +: PLAIN_W];
    assign q_lost     = q_rdata[ITEM_W-1];

    lpps_back #(
        .PLAIN_W  (PLAIN_W),
        .WEIGHT_W (WEIGHT_W)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .empty           (empty),
        .pop             (pop),
        .q_weighted      (q_weighted),
        .q_plain         (q_plain),
        .q_lost          (q_lost),
        .prop_gain       (prop_gain_reg),
        .integ_gain      (integ_gain_reg),
        .deriv_gain      (deriv_gain_reg),
        .target_position (target_reg),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .position        (position),
        .line_lost       (line_lost),
        .drive           (drive),
        .turn_right      (turn_right)
    );

endmodule

### rtl/lpps_front.sv
// Front end: takes one sensor frame, forms plain and weighted sums one lane per cycle.
// Depends on lpps_pkg; feeds lpps_queue.
module lpps_front #(
    parameter int SENSOR_COUNT = lpps_pkg::SENSOR_COUNT_DEF,
    parameter int SAMPLE_BITS  = lpps_pkg::SAMPLE_BITS_DEF,
    parameter int PLAIN_W      = lpps_pkg::plain_width(SENSOR_COUNT, SAMPLE_BITS),
    parameter int WEIGHT_W     = lpps_pkg::weight_width(SENSOR_COUNT, SAMPLE_BITS)
) (
    input  logic                                                      clk,
    input  logic                                                      rst_n,
    input  logic                                                      in_valid,
    output logic                                                      in_stall,
    input  logic [lpps_pkg::INPUT_COUNT-1:0][lpps_pkg::DATA_BITS-1:0] sensors,
    output logic                                                      push,
    input  logic                                                      full,
    output logic [WEIGHT_W-1:0]                                       weighted,
    output logic [PLAIN_W-1:0]                                        plain,
    output logic                                                      lost
);

    localparam int CNT_W = $clog2(SENSOR_COUNT);

    lpps_pkg::front_state_t state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [SAMPLE_BITS-1:0] lane_reg  [SENSOR_COUNT];
    logic [SAMPLE_BITS-1:0] lane_next [SENSOR_COUNT];
    logic [PLAIN_W-1:0]     plain_reg, plain_next;
    logic [WEIGHT_W-1:0]    weight_reg, weight_next;

    // Next state, lane shift and running sums
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        lane_next   = lane_reg;
        plain_next  = plain_reg;
        weight_next = weight_reg;
        push        = 1'b0;
        case (state_reg)
            lpps_pkg::F_IDLE:
            begin
                if (in_valid)
                begin
                    for (int k = 0; k < SENSOR_COUNT; k++)
                    begin
                        lane_next[k] = sensors[k][SAMPLE_BITS-1:0];
                    end
                    plain_next  = '0;
                    weight_next = '0;
                    cnt_next    = CNT_W'(SENSOR_COUNT - 1);
                    state_next  = lpps_pkg::F_SUM;
                end
            end
            lpps_pkg::F_SUM:
            begin
                // Highest lane first: it lands in every later partial sum
                plain_next  = plain_reg + PLAIN_W'(lane_reg[SENSOR_COUNT-1]);
                weight_next = weight_reg + WEIGHT_W'(plain_next);
                for (int k = SENSOR_COUNT - 1; k > 0; k--)
                begin
                    lane_next[k] = lane_reg[k-1];
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = lpps_pkg::F_PUSH;
                end
            end
            lpps_pkg::F_PUSH:
            begin
                if (!full)
                begin
                    push       = 1'b1;
                    state_next = lpps_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = lpps_pkg::F_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lpps_pkg::F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        lane_reg   <= lane_next;
        plain_reg  <= plain_next;
        weight_reg <= weight_next;
    end

    assign in_stall = (state_reg != lpps_pkg::F_IDLE);
    assign weighted = weight_reg;
    assign plain    = plain_reg;
    assign lost     = (plain_reg == '0);

endmodule

### rtl/lpps_queue.sv
// Short queue between the summing front end and the divide/PID back end.
// Depends on lpps_pkg for its depth.
module lpps_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int DEPTH = lpps_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    // Store on push
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign rdata = mem[rd_ptr_reg];
    assign full  = (count_reg == (PTR_W + 1)'(DEPTH));
    assign empty = (count_reg == '0);

endmodule

### rtl/lpps_back.sv
// Back end: bit-serial centroid divide, shared-multiplier PID step and output register.
// Depends on lpps_pkg; drains lpps_queue.
module lpps_back #(
    parameter int PLAIN_W  = 19,
    parameter int WEIGHT_W = 22
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 empty,
    output logic                                 pop,
    input  logic [WEIGHT_W-1:0]                  q_weighted,
    input  logic [PLAIN_W-1:0]                   q_plain,
    input  logic                                 q_lost,
    input  logic [lpps_pkg::GAIN_BITS-1:0]       prop_gain,
    input  logic [lpps_pkg::GAIN_BITS-1:0]       integ_gain,
    input  logic [lpps_pkg::GAIN_BITS-1:0]       deriv_gain,
    input  logic [lpps_pkg::POS_BITS-1:0]        target_position,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [lpps_pkg::POS_BITS-1:0]        position,
    output logic                                 line_lost,
    output logic signed [lpps_pkg::DRIVE_BITS-1:0] drive,
    output logic                                 turn_right
);

    localparam int POS_BITS  = lpps_pkg::POS_BITS;
    localparam int ERR_BITS  = lpps_pkg::ERR_BITS;
    localparam int INTEG_BITS = lpps_pkg::INTEG_BITS;
    localparam int ACC_BITS  = lpps_pkg::ACC_BITS;
    localparam int DIVD_W    = WEIGHT_W + lpps_pkg::FRAC_BITS;
    localparam int REM_W     = (DIVD_W > PLAIN_W + POS_BITS) ? DIVD_W : PLAIN_W + POS_BITS;
    localparam int QCNT_W    = $clog2(POS_BITS);
    localparam logic signed [ACC_BITS-1:0] LIM_HI = ACC_BITS'(lpps_pkg::DRIVE_LIMIT);
    localparam logic signed [ACC_BITS-1:0] LIM_LO = -LIM_HI;
    localparam logic signed [INTEG_BITS-1:0] INTEG_MAX = {1'b0, {(INTEG_BITS-1){1'b1}}};
    localparam logic signed [INTEG_BITS-1:0] INTEG_MIN = {1'b1, {(INTEG_BITS-1){1'b0}}};

    lpps_pkg::back_state_t state_reg, state_next;
    logic [QCNT_W-1:0]     cnt_reg, cnt_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [REM_W-1:0]      dvs_reg, dvs_next;
    logic [POS_BITS-1:0]   pos_reg, pos_next;
    logic                  lost_reg, lost_next;
    logic signed [ERR_BITS-1:0]   err_reg, err_next;
    logic signed [ERR_BITS-1:0]   prev_reg, prev_next;
    logic signed [INTEG_BITS-1:0] integ_reg, integ_next;
    logic [POS_BITS-1:0]   last_reg, last_next;
    logic signed [lpps_pkg::PROD_BITS-1:0]  prod_reg, prod_next;
    logic signed [ACC_BITS-1:0]             acc_reg, acc_next;
    logic signed [lpps_pkg::MUL_A_BITS-1:0] mul_a;
    logic signed [lpps_pkg::MUL_B_BITS-1:0] mul_b;
    logic signed [ERR_BITS:0]               derr;
    logic signed [ACC_BITS-1:0]             acc_shift;
    logic signed [lpps_pkg::DRIVE_BITS-1:0] drive_c;
    logic signed [INTEG_BITS:0]             integ_sum;
    logic signed [INTEG_BITS-1:0]           integ_sat;
    logic                                   take;

    logic                                   out_valid_reg, out_valid_next;
    logic [POS_BITS-1:0]                    position_reg, position_next;
    logic                                   line_lost_reg, line_lost_next;
    logic signed [lpps_pkg::DRIVE_BITS-1:0] drive_reg, drive_next;
    logic                                   turn_right_reg, turn_right_next;

    // Derivative term, floor shift and clamp, saturating integral update
    always_comb
    begin
        derr      = (ERR_BITS + 1)'(err_reg) - (ERR_BITS + 1)'(prev_reg);
        acc_shift = acc_reg >>> lpps_pkg::ACC_SHIFT;
        if (acc_shift > LIM_HI)
        begin
            drive_c = lpps_pkg::DRIVE_BITS'(LIM_HI);
        end
        else if (acc_shift < LIM_LO)
        begin
            drive_c = lpps_pkg::DRIVE_BITS'(LIM_LO);
        end
        else
        begin
            drive_c = lpps_pkg::DRIVE_BITS'(acc_shift);
        end
        integ_sum = (INTEG_BITS + 1)'(integ_reg) + (INTEG_BITS + 1)'(err_reg);
        if (integ_sum[INTEG_BITS] != integ_sum[INTEG_BITS-1])
        begin
            integ_sat = integ_sum[INTEG_BITS] ? INTEG_MIN : INTEG_MAX;
        end
        else
        begin
            integ_sat = integ_sum[INTEG_BITS-1:0];
        end
        take = (rem_reg >= dvs_reg);
    end

    // Sequencer: pop, divide (skipped for a lost line), error, three multiply-accumulate steps, load output
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rem_next        = rem_reg;
        dvs_next        = dvs_reg;
        pos_next        = pos_reg;
        lost_next       = lost_reg;
        err_next        = err_reg;
        prev_next       = prev_reg;
        integ_next      = integ_reg;
        last_next       = last_reg;
        acc_next        = acc_reg;
        mul_a           = '0;
        mul_b           = '0;
        pop             = 1'b0;
        out_valid_next  = out_valid_reg && out_stall;
        position_next   = position_reg;
        line_lost_next  = line_lost_reg;
        drive_next      = drive_reg;
        turn_right_next = turn_right_reg;
        case (state_reg)
            lpps_pkg::B_IDLE:
            begin
                if (!empty)
                begin
                    pop       = 1'b1;
                    lost_next = q_lost;
                    if (q_lost)
                    begin
                        pos_next   = last_reg;
                        state_next = lpps_pkg::B_ERR;
                    end
                    else
                    begin
                        rem_next   = REM_W'({q_weighted, {lpps_pkg::FRAC_BITS{1'b0}}});
                        dvs_next   = REM_W'(q_plain) << (POS_BITS - 1);
                        cnt_next   = QCNT_W'(POS_BITS - 1);
                        state_next = lpps_pkg::B_DIV;
                    end
                end
            end
            lpps_pkg::B_DIV:
            begin
                // One quotient bit per cycle, most significant first
                if (take)
                begin
                    rem_next = rem_reg - dvs_reg;
                end
                pos_next = {pos_reg[POS_BITS-2:0], take};
                dvs_next = dvs_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = lpps_pkg::B_ERR;
                end
            end
            lpps_pkg::B_ERR:
            begin
                err_next   = $signed(ERR_BITS'(target_position)) - $signed(ERR_BITS'(pos_reg));
                state_next = lpps_pkg::B_MP;
            end
            lpps_pkg::B_MP:
            begin
                mul_a      = $signed({1'b0, prop_gain});
                mul_b      = INTEG_BITS'(err_reg);
                state_next = lpps_pkg::B_MI;
            end
            lpps_pkg::B_MI:
            begin
                mul_a      = $signed({1'b0, integ_gain});
                mul_b      = integ_reg;
                acc_next   = ACC_BITS'(prod_reg);
                state_next = lpps_pkg::B_MD;
            end
            lpps_pkg::B_MD:
            begin
                mul_a      = $signed({1'b0, deriv_gain});
                mul_b      = INTEG_BITS'(derr);
                acc_next   = acc_reg + ACC_BITS'(prod_reg);
                state_next = lpps_pkg::B_SUM;
            end
            lpps_pkg::B_SUM:
            begin
                acc_next   = acc_reg + ACC_BITS'(prod_reg);
                state_next = lpps_pkg::B_DONE;
            end
            lpps_pkg::B_DONE:
            begin
                // Hold until the output register is free or being drained
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    position_next   = pos_reg;
                    line_lost_next  = lost_reg;
                    drive_next      = drive_c;
                    turn_right_next = (drive_c > 0);
                    integ_next      = integ_sat;
                    prev_next       = err_reg;
                    if (!lost_reg)
                    begin
                        last_next = pos_reg;
                    end
                    state_next = lpps_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = lpps_pkg::B_IDLE;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    // Control and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lpps_pkg::B_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            integ_reg     <= '0;
            prev_reg      <= '0;
            last_reg      <= lpps_pkg::TARGET_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            integ_reg     <= integ_next;
            prev_reg      <= prev_next;
            last_reg      <= last_next;
        end
    end

    // Datapath and output payload
    always_ff @(posedge clk)
    begin
        rem_reg        <= rem_next;
        dvs_reg        <= dvs_next;
        pos_reg        <= pos_next;
        lost_reg       <= lost_next;
        err_reg        <= err_next;
        prod_reg       <= prod_next;
        acc_reg        <= acc_next;
        position_reg   <= position_next;
        line_lost_reg  <= line_lost_next;
        drive_reg      <= drive_next;
        turn_right_reg <= turn_right_next;
    end

    assign out_valid  = out_valid_reg;
    assign position   = position_reg;
    assign line_lost  = line_lost_reg;
    assign drive      = drive_reg;
    assign turn_right = turn_right_reg;

    // Drive stays inside the clamp window
    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (drive_reg <= 10'sd510) && (drive_reg >= -10'sd510))
        else $error("drive outside clamp window");

    // Direction follows the sign of drive
    a_turn_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (turn_right_reg == (drive_reg > 0)))
        else $error("turn direction does not match drive");

    // A found line yields a centroid of at least one sensor pitch
    a_pos_min: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !line_lost_reg) |-> (position_reg >= POS_BITS'(lpps_pkg::POS_MIN)))
        else $error("centroid below first sensor");

    // Queue is only drained from the idle state
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == lpps_pkg::B_IDLE) && !empty)
        else $error("pop outside idle or from empty queue");

endmodule
